// ----- rtl/gfp_pkg.sv -----
// shared constants for the gnomonic forward projection core
package gfp_pkg;

  // sine polynomial coefficients, q18
  localparam int SIN_A = 411775;
  localparam int SIN_B = 168190;
  localparam int SIN_C = 18559;

  // configuration register indexes
  localparam logic [2:0] CFG_CENTER_LON = 3'd0;
  localparam logic [2:0] CFG_CENTER_LAT = 3'd1;
  localparam logic [2:0] CFG_RADIUS     = 3'd2;
  localparam logic [2:0] CFG_WIDTH      = 3'd3;
  localparam logic [2:0] CFG_HEIGHT     = 3'd4;

  typedef enum logic [1:0] {
    STATUS_VISIBLE,
    STATUS_HIDDEN,
    STATUS_OFFSCREEN
  } status_t;

endpackage

// ----- rtl/gnomonic_forward_projection_core.sv -----
// gnomonic forward projection core: angles in, screen coordinates and status out
//
// Input channel: in_valid/in_stall carry one point (point_longitude,
// point_latitude). Output channel: out_valid/out_stall carry screen_x,
// screen_y and status. A transaction happens when valid is high and stall low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Registers are read live by the stages that use them, so write
// them only while no point is in flight.
// Throughput: one point per cycle while out_stall is low. The pipeline has five
// stages of sine polynomial, two of spherical products, three of magnitude and
// scaling, one divider setup stage, one restoring-divider stage per quotient
// bit, and three of clip test, screen offset and output.
// Each stage holds while the stage after it is full and held, so an output
// stall backs up only as far as the pipeline is occupied; nothing is lost.
// Reset clears all stage valid bits and loads the default view (center 0,0,
// radius 256, screen 640 by 480).
module gnomonic_forward_projection_core #(
  parameter int ANGLE_BITS      = 16,
  parameter int COORD_FRAC_BITS = 4,
  parameter int SCREEN_BITS     = 13
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic signed [ANGLE_BITS-1:0]              point_longitude,
  input  logic signed [ANGLE_BITS-1:0]              point_latitude,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [SCREEN_BITS+COORD_FRAC_BITS+1:0] screen_x,
  output logic signed [SCREEN_BITS+COORD_FRAC_BITS+1:0] screen_y,
  output logic [1:0]                                status,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [2:0]                                cfg_index,
  input  logic [(ANGLE_BITS > SCREEN_BITS ? ANGLE_BITS : SCREEN_BITS)-1:0] cfg_data
);

  localparam int F    = COORD_FRAC_BITS;
  localparam int LW   = SCREEN_BITS + F;        // pixel limit width
  localparam int OW   = LW + 2;                 // output width
  localparam int QB   = LW + 1;                 // quotient bits
  localparam int EW   = QB + 2;                 // screen sum width
  localparam int DW   = 35;                     // divisor width
  localparam int SCW  = SCREEN_BITS - 1 + F;    // scale width
  localparam int LOW  = 18 + SCW;
  localparam int HIW  = 17 + SCW;
  localparam int NW   = DW + SCW;               // numerator width
  localparam int S_FOLD = 0;
  localparam int S_SQ   = 1;
  localparam int S_T1   = 2;
  localparam int S_T2   = 3;
  localparam int S_SIN  = 4;
  localparam int S_PROD = 5;
  localparam int S_SUM  = 6;
  localparam int S_ABS  = 7;
  localparam int S_PART = 8;
  localparam int S_NUM  = 9;
  localparam int S_PRE  = 10;
  localparam int S_SQR  = 11 + QB;
  localparam int S_CHK  = 12 + QB;
  localparam int S_OUT  = 13 + QB;
  localparam int NST    = 14 + QB;
  localparam logic signed [EW-1:0] SAT_LO = EW'(-(64'sd1 <<< LW));
  localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (LW + 1)) - 64'sd1);

  // configuration registers
  logic [ANGLE_BITS-1:0]  center_longitude;
  logic [ANGLE_BITS-1:0]  center_latitude;
  logic [SCREEN_BITS-1:0] globe_radius;
  logic [SCREEN_BITS-1:0] view_width;
  logic [SCREEN_BITS-1:0] view_height;
  logic [2*LW-1:0]        limsq;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_longitude <= '0;
      center_latitude  <= '0;
      globe_radius     <= SCREEN_BITS'(256);
      view_width       <= SCREEN_BITS'(640);
      view_height      <= SCREEN_BITS'(480);
    end else if (cfg_valid) begin
      case (cfg_index)
        gfp_pkg::CFG_CENTER_LON: center_longitude <= cfg_data[ANGLE_BITS-1:0];
        gfp_pkg::CFG_CENTER_LAT: center_latitude  <= cfg_data[ANGLE_BITS-1:0];
        gfp_pkg::CFG_RADIUS:     globe_radius     <= cfg_data[SCREEN_BITS-1:0];
        gfp_pkg::CFG_WIDTH:      view_width       <= cfg_data[SCREEN_BITS-1:0];
        gfp_pkg::CFG_HEIGHT:     view_height      <= cfg_data[SCREEN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // squared clip radius follows the radius register
  logic [LW-1:0] limv;
  assign limv = LW'(globe_radius) << F;
  always_ff @(posedge clk) begin
    limsq <= (2*LW)'(limv) * (2*LW)'(limv);
  end

  // stage handshake
  logic [NST-1:0] v;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !v[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // fold a 20-bit turn fraction into the quarter wave
  function automatic logic signed [19:0] fold(input logic [19:0] s);
    logic signed [20:0] w;
    logic signed [20:0] r;
    w = $signed({s[19], s});
    if (w > 21'sd262144) r = 21'sd524288 - w;
    else if (w < -21'sd262144) r = -21'sd524288 - w;
    else r = w;
    return r[19:0];
  endfunction

  // lanes: 0 sin lat, 1 cos lat, 2 sin lat1, 3 cos lat1, 4 sin dlon, 5 cos dlon
  logic [31:0] ph_lat, ph_lat1, ph_dlon;
  logic [19:0] s_in [6];

  always_comb begin
    ph_lat  = {point_latitude, {(32-ANGLE_BITS){1'b0}}};
    ph_lat1 = {center_latitude, {(32-ANGLE_BITS){1'b0}}};
    ph_dlon = {point_longitude, {(32-ANGLE_BITS){1'b0}}}
            - {center_longitude, {(32-ANGLE_BITS){1'b0}}};
    s_in[0] = ph_lat[31:12];
    s_in[1] = ph_lat[31:12] + 20'h40000;
    s_in[2] = ph_lat1[31:12];
    s_in[3] = ph_lat1[31:12] + 20'h40000;
    s_in[4] = ph_dlon[31:12];
    s_in[5] = ph_dlon[31:12] + 20'h40000;
  end

  // sine pipeline registers
  logic signed [19:0] f_s [6];
  logic signed [19:0] q_s [6];
  logic [18:0]        q_x2 [6];
  logic signed [19:0] a_s [6];
  logic [18:0]        a_x2 [6];
  logic [17:0]        a_t1 [6];
  logic signed [19:0] b_s [6];
  logic [18:0]        b_t2 [6];
  logic signed [17:0] c_sin [6];

  logic signed [39:0] m_sq [6];
  logic [33:0]        m_c [6];
  logic [36:0]        m_t [6];
  logic signed [39:0] m_s [6];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      m_sq[i] = f_s[i] * f_s[i];
      m_c[i]  = 34'(q_x2[i]) * 34'(gfp_pkg::SIN_C);
      m_t[i]  = 37'(a_x2[i]) * 37'(a_t1[i]);
      m_s[i]  = b_s[i] * $signed({1'b0, b_t2[i]});
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      if (en[S_FOLD]) f_s[i] <= fold(s_in[i]);
      if (en[S_SQ]) begin
        q_s[i]  <= f_s[i];
        q_x2[i] <= m_sq[i][36:18];
      end
      if (en[S_T1]) begin
        a_s[i]  <= q_s[i];
        a_x2[i] <= q_x2[i];
        a_t1[i] <= 18'(gfp_pkg::SIN_B) - 18'(m_c[i][33:18]);
      end
      if (en[S_T2]) begin
        b_s[i]  <= a_s[i];
        b_t2[i] <= 19'(gfp_pkg::SIN_A) - 19'(m_t[i][36:18]);
      end
      if (en[S_SIN]) c_sin[i] <= m_s[i][37:20];
    end
  end

  // spherical products
  logic signed [35:0] p1, p3, p_xn;
  logic signed [19:0] p2, p4;
  logic signed [17:0] p_cd;
  logic signed [35:0] m_p2, m_p4;

  always_comb begin
    m_p2 = c_sin[3] * c_sin[1];
    m_p4 = c_sin[2] * c_sin[1];
  end

  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      p1   <= c_sin[2] * c_sin[0];
      p3   <= c_sin[3] * c_sin[0];
      p_xn <= c_sin[1] * c_sin[4];
      p2   <= m_p2[35:16];
      p4   <= m_p4[35:16];
      p_cd <= c_sin[5];
    end
  end

  logic signed [37:0] m_cz, m_cy;
  logic signed [35:0] cosc, yn, xn;

  always_comb begin
    m_cz = p2 * p_cd;
    m_cy = p4 * p_cd;
  end

  always_ff @(posedge clk) begin
    if (en[S_SUM]) begin
      cosc <= p1 + m_cz[35:0];
      yn   <= p3 - m_cy[35:0];
      xn   <= p_xn;
    end
  end

  // magnitudes and signs
  logic          ab_hid, ab_sgx, ab_sgy;
  logic [DW-1:0] ab_d, ab_x, ab_y;
  logic [35:0]   neg_x, neg_y;

  always_comb begin
    neg_x = -xn;
    neg_y = -yn;
  end

  always_ff @(posedge clk) begin
    if (en[S_ABS]) begin
      ab_hid <= cosc[35] || (cosc == 36'sd0);
      ab_d   <= cosc[DW-1:0];
      ab_sgx <= xn[35];
      ab_sgy <= yn[35];
      ab_x   <= xn[35] ? neg_x[DW-1:0] : xn[DW-1:0];
      ab_y   <= yn[35] ? neg_y[DW-1:0] : yn[DW-1:0];
    end
  end

  // numerator times scale, split in two partial products
  logic [SCW-1:0] scale;
  logic [LOW-1:0] pt_lox, pt_loy;
  logic [HIW-1:0] pt_hix, pt_hiy;
  logic           pt_hid, pt_sgx, pt_sgy;
  logic [DW-1:0]  pt_d;

  assign scale = SCW'(globe_radius >> 1) << F;

  always_ff @(posedge clk) begin
    if (en[S_PART]) begin
      pt_lox <= LOW'(ab_x[17:0]) * LOW'(scale);
      pt_loy <= LOW'(ab_y[17:0]) * LOW'(scale);
      pt_hix <= HIW'(ab_x[DW-1:18]) * HIW'(scale);
      pt_hiy <= HIW'(ab_y[DW-1:18]) * HIW'(scale);
      pt_hid <= ab_hid;
      pt_sgx <= ab_sgx;
      pt_sgy <= ab_sgy;
      pt_d   <= ab_d;
    end
  end

  logic [NW-1:0] nm_x, nm_y;
  logic          nm_hid, nm_sgx, nm_sgy;
  logic [DW-1:0] nm_d;

  always_ff @(posedge clk) begin
    if (en[S_NUM]) begin
      nm_x   <= (NW'(pt_hix) << 18) + NW'(pt_lox);
      nm_y   <= (NW'(pt_hiy) << 18) + NW'(pt_loy);
      nm_hid <= pt_hid;
      nm_sgx <= pt_sgx;
      nm_sgy <= pt_sgy;
      nm_d   <= pt_d;
    end
  end

  // restoring divider, one quotient bit per stage
  logic [DW-1:0] dv_rx [QB+1];
  logic [DW-1:0] dv_ry [QB+1];
  logic [QB-1:0] dv_qx [QB+1];
  logic [QB-1:0] dv_qy [QB+1];
  logic [QB-1:0] dv_lx [QB+1];
  logic [QB-1:0] dv_ly [QB+1];
  logic [DW-1:0] dv_d  [QB+1];
  logic          dv_hid [QB+1];
  logic          dv_ovx [QB+1];
  logic          dv_ovy [QB+1];
  logic          dv_sgx [QB+1];
  logic          dv_sgy [QB+1];

  logic [NW-1:0] top_x, top_y, d_ext;
  logic [DW:0]   tx [QB];
  logic [DW:0]   ty [QB];
  logic [DW:0]   sx_d [QB];
  logic [DW:0]   sy_d [QB];
  logic          gx [QB];
  logic          gy [QB];

  always_comb begin
    top_x = nm_x >> QB;
    top_y = nm_y >> QB;
    d_ext = NW'(nm_d);
    for (int j = 0; j < QB; j++) begin
      tx[j]   = {dv_rx[j], dv_lx[j][QB-1]};
      ty[j]   = {dv_ry[j], dv_ly[j][QB-1]};
      gx[j]   = tx[j] >= {1'b0, dv_d[j]};
      gy[j]   = ty[j] >= {1'b0, dv_d[j]};
      sx_d[j] = tx[j] - {1'b0, dv_d[j]};
      sy_d[j] = ty[j] - {1'b0, dv_d[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_PRE]) begin
      dv_rx[0]  <= top_x[DW-1:0];
      dv_ry[0]  <= top_y[DW-1:0];
      dv_qx[0]  <= '0;
      dv_qy[0]  <= '0;
      dv_lx[0]  <= nm_x[QB-1:0];
      dv_ly[0]  <= nm_y[QB-1:0];
      dv_d[0]   <= nm_d;
      dv_hid[0] <= nm_hid;
      dv_ovx[0] <= top_x >= d_ext;
      dv_ovy[0] <= top_y >= d_ext;
      dv_sgx[0] <= nm_sgx;
      dv_sgy[0] <= nm_sgy;
    end
    for (int j = 0; j < QB; j++) begin
      if (en[S_PRE+1+j]) begin
        dv_rx[j+1]  <= gx[j] ? sx_d[j][DW-1:0] : tx[j][DW-1:0];
        dv_ry[j+1]  <= gy[j] ? sy_d[j][DW-1:0] : ty[j][DW-1:0];
        dv_qx[j+1]  <= {dv_qx[j][QB-2:0], gx[j]};
        dv_qy[j+1]  <= {dv_qy[j][QB-2:0], gy[j]};
        dv_lx[j+1]  <= dv_lx[j] << 1;
        dv_ly[j+1]  <= dv_ly[j] << 1;
        dv_d[j+1]   <= dv_d[j];
        dv_hid[j+1] <= dv_hid[j];
        dv_ovx[j+1] <= dv_ovx[j];
        dv_ovy[j+1] <= dv_ovy[j];
        dv_sgx[j+1] <= dv_sgx[j];
        dv_sgy[j+1] <= dv_sgy[j];
      end
    end
  end

  // clip radius: squares and box test
  logic [QB-1:0]      qx, qy;
  logic [2*QB-1:0]    sq_x, sq_y;
  logic signed [QB:0] sq_vx, sq_vy;
  logic               sq_hid, sq_far;

  assign qx = dv_qx[QB];
  assign qy = dv_qy[QB];

  always_ff @(posedge clk) begin
    if (en[S_SQR]) begin
      sq_x   <= (2*QB)'(qx) * (2*QB)'(qx);
      sq_y   <= (2*QB)'(qy) * (2*QB)'(qy);
      sq_vx  <= dv_sgx[QB] ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
      sq_vy  <= dv_sgy[QB] ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      sq_hid <= dv_hid[QB];
      sq_far <= dv_ovx[QB] || dv_ovy[QB] || (qx > QB'(limv)) || (qy > QB'(limv));
    end
  end

  // move to the screen center, y grows downward
  logic [LW-1:0]       half_w, half_h;
  logic [2*QB:0]       sq_sum;
  logic signed [EW-1:0] ck_sx, ck_sy;
  logic                ck_hidden;

  assign half_w = LW'(view_width >> 1) << F;
  assign half_h = LW'(view_height >> 1) << F;
  assign sq_sum = (2*QB+1)'(sq_x) + (2*QB+1)'(sq_y);

  always_ff @(posedge clk) begin
    if (en[S_CHK]) begin
      ck_hidden <= sq_hid || sq_far || (sq_sum > (2*QB+1)'(limsq));
      ck_sx     <= {sq_vx[QB], sq_vx} + $signed(EW'(half_w));
      ck_sy     <= $signed(EW'(half_h)) - {sq_vy[QB], sq_vy};
    end
  end

  // screen bounds and saturation
  logic signed [EW-1:0] wl, hl, sat_x, sat_y;
  logic                 off;

  always_comb begin
    wl  = $signed(EW'(LW'(view_width) << F));
    hl  = $signed(EW'(LW'(view_height) << F));
    off = ck_sx[EW-1] || (ck_sx >= wl) || ck_sy[EW-1] || (ck_sy >= hl);
    if (ck_sx < SAT_LO) sat_x = SAT_LO;
    else if (ck_sx > SAT_HI) sat_x = SAT_HI;
    else sat_x = ck_sx;
    if (ck_sy < SAT_LO) sat_y = SAT_LO;
    else if (ck_sy > SAT_HI) sat_y = SAT_HI;
    else sat_y = ck_sy;
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      if (ck_hidden) begin
        screen_x <= '0;
        screen_y <= '0;
        status   <= gfp_pkg::STATUS_HIDDEN;
      end else begin
        screen_x <= sat_x[OW-1:0];
        screen_y <= sat_y[OW-1:0];
        status   <= off ? gfp_pkg::STATUS_OFFSCREEN : gfp_pkg::STATUS_VISIBLE;
      end
    end
  end

endmodule
